// File: rtl/core/sot_pkg.sv
`timescale 1ns / 1ps
// sot_pkg: shared widths, pair-kind codes and stage record types for shape_overlap_test
// depends on nothing

package sot_pkg;

    // field widths
    localparam int POS_W  = 24;             // signed Q15.8 position
    localparam int EXT_W  = 22;             // unsigned Q14.8 extent
    localparam int FAR_W  = POS_W + 1;      // far edge, never wraps
    localparam int DIF_W  = POS_W + 2;      // signed difference with headroom
    localparam int GAP_W  = POS_W + 1;      // gap magnitude, at most 2^24
    localparam int RAD_W  = EXT_W + 1;      // radius sum of two circles
    localparam int SQ_W   = 2 * GAP_W;      // squared gap
    localparam int RSQ_W  = 2 * RAD_W;      // squared radius
    localparam int SUM_W  = SQ_W + 1;       // sum of two squared gaps

    // pair kinds
    localparam logic [1:0] MODE_CIRC_CIRC = 2'd0;
    localparam logic [1:0] MODE_BOX_BOX   = 2'd1;
    localparam logic [1:0] MODE_CIRC_BOX  = 2'd2;

    // stage 1: shapes sorted, far edges formed
    typedef struct packed {
        logic [1:0]               mode;
        logic signed [POS_W-1:0]  p_x;
        logic signed [POS_W-1:0]  p_y;
        logic signed [POS_W-1:0]  q_x;
        logic signed [POS_W-1:0]  q_y;
        logic signed [FAR_W-1:0]  p_far_x;
        logic signed [FAR_W-1:0]  p_far_y;
        logic signed [FAR_W-1:0]  q_far_x;
        logic signed [FAR_W-1:0]  q_far_y;
        logic [RAD_W-1:0]         radius;
    } t_s1;

    // stage 2: per-axis gaps and box-box verdict
    typedef struct packed {
        logic                     is_bb;
        logic                     bb_hit;
        logic [GAP_W-1:0]         gap_x;
        logic [GAP_W-1:0]         gap_y;
        logic [RAD_W-1:0]         radius;
    } t_s2;

    // stage 3: squares
    typedef struct packed {
        logic                     is_bb;
        logic                     bb_hit;
        logic [SQ_W-1:0]          sq_x;
        logic [SQ_W-1:0]          sq_y;
        logic [RSQ_W-1:0]         rsq;
    } t_s3;

endpackage

// File: rtl/core/shape_overlap_test.sv
`timescale 1ns / 1ps
// shape_overlap_test: four-stage pipelined 2d contact test for circles and boxes
// depends on sot_pkg
//
// usage
//   input channel: i_valid with the two shape descriptions, o_stall back to the
//   sender; a transfer happens on a rising edge with i_valid high, o_stall low.
//   output channel: o_valid with o_touching, i_stall from the receiver.
//   an input transfer loads stage 1; the pair then moves through stages 2, 3
//   and 4, and o_valid rises once stage 4 holds its result.
//   throughput: one pair per cycle unless stalled; stage 1 sorts the shapes
//   and forms far edges, stage 2 takes per-axis gaps, stage 3 squares them on two
//   25x25 and one 23x23 multiplier, stage 4 sums, compares and holds the result.
//   each stage advances when it is empty or the stage after it moves, so
//   bubbles close up under stall and items are neither lost nor repeated.
//   when the receiver stalls and all four stages hold items, o_stall rises
//   in the same cycle; o_touching holds while o_valid waits.
//   reset (i_rst_n low, synchronous) empties the pipeline by clearing the
//   valid bits; the payload registers are not reset.

module shape_overlap_test
    import sot_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_a_is_circle,
    input  logic signed [POS_W-1:0] i_a_pos_x,
    input  logic signed [POS_W-1:0] i_a_pos_y,
    input  logic [EXT_W-1:0]        i_a_extent_x,
    input  logic [EXT_W-1:0]        i_a_extent_y,
    input  logic                    i_b_is_circle,
    input  logic signed [POS_W-1:0] i_b_pos_x,
    input  logic signed [POS_W-1:0] i_b_pos_y,
    input  logic [EXT_W-1:0]        i_b_extent_x,
    input  logic [EXT_W-1:0]        i_b_extent_y,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic                    o_touching
);

    // distance from a circle centre (or a's position) to the other shape on one axis
    function automatic logic [GAP_W-1:0] axis_gap(
        input logic [1:0]              mode,
        input logic signed [POS_W-1:0] p,
        input logic signed [POS_W-1:0] q,
        input logic signed [FAR_W-1:0] q_far
    );
        logic signed [DIF_W-1:0] dp;
        logic signed [DIF_W-1:0] dn;
        logic signed [DIF_W-1:0] dh;
        logic [GAP_W-1:0]        g;
        dp = DIF_W'(p) - DIF_W'(q);
        dn = DIF_W'(q) - DIF_W'(p);
        dh = DIF_W'(p) - DIF_W'(q_far);
        priority if (dp < 0) begin
            g = dn[GAP_W-1:0];
        end else if (mode != MODE_CIRC_BOX) begin
            g = dp[GAP_W-1:0];
        end else if (dh > 0) begin
            g = dh[GAP_W-1:0];
        end else begin
            g = '0;
        end
        return g;
    endfunction

    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_s3  r_s3, n_s3;
    logic r_hit, n_hit;

    // stage advance: a stage moves when empty or when the next one moves
    assign en4     = !r_v4 || !i_stall;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;

    // stage 1: pair kind, circle first in mixed pairs, far edges and radius
    always_comb begin
        logic swap;
        swap = !i_a_is_circle && i_b_is_circle;
        if (i_a_is_circle && i_b_is_circle) begin
            n_s1.mode = MODE_CIRC_CIRC;
        end else if (!i_a_is_circle && !i_b_is_circle) begin
            n_s1.mode = MODE_BOX_BOX;
        end else begin
            n_s1.mode = MODE_CIRC_BOX;
        end
        n_s1.p_x     = swap ? i_b_pos_x : i_a_pos_x;
        n_s1.p_y     = swap ? i_b_pos_y : i_a_pos_y;
        n_s1.q_x     = swap ? i_a_pos_x : i_b_pos_x;
        n_s1.q_y     = swap ? i_a_pos_y : i_b_pos_y;
        n_s1.p_far_x = FAR_W'(i_a_pos_x) + $signed({3'b000, i_a_extent_x});
        n_s1.p_far_y = FAR_W'(i_a_pos_y) + $signed({3'b000, i_a_extent_y});
        n_s1.q_far_x = swap ? FAR_W'(i_a_pos_x) + $signed({3'b000, i_a_extent_x})
                            : FAR_W'(i_b_pos_x) + $signed({3'b000, i_b_extent_x});
        n_s1.q_far_y = swap ? FAR_W'(i_a_pos_y) + $signed({3'b000, i_a_extent_y})
                            : FAR_W'(i_b_pos_y) + $signed({3'b000, i_b_extent_y});
        if (n_s1.mode == MODE_CIRC_CIRC) begin
            n_s1.radius = {1'b0, i_a_extent_x} + {1'b0, i_b_extent_x};
        end else begin
            n_s1.radius = {1'b0, swap ? i_b_extent_x : i_a_extent_x};
        end
    end

    // stage 2: per-axis gaps and inclusive box overlap
    always_comb begin
        logic apart;
        apart = (r_s1.p_far_x < FAR_W'(r_s1.q_x)) || (FAR_W'(r_s1.p_x) > r_s1.q_far_x) ||
                (r_s1.p_far_y < FAR_W'(r_s1.q_y)) || (FAR_W'(r_s1.p_y) > r_s1.q_far_y);
        n_s2.is_bb  = (r_s1.mode == MODE_BOX_BOX);
        n_s2.bb_hit = !apart;
        n_s2.gap_x  = axis_gap(r_s1.mode, r_s1.p_x, r_s1.q_x, r_s1.q_far_x);
        n_s2.gap_y  = axis_gap(r_s1.mode, r_s1.p_y, r_s1.q_y, r_s1.q_far_y);
        n_s2.radius = r_s1.radius;
    end

    // stage 3: squares
    always_comb begin
        n_s3.is_bb  = r_s2.is_bb;
        n_s3.bb_hit = r_s2.bb_hit;
        n_s3.sq_x   = SQ_W'(r_s2.gap_x) * SQ_W'(r_s2.gap_x);
        n_s3.sq_y   = SQ_W'(r_s2.gap_y) * SQ_W'(r_s2.gap_y);
        n_s3.rsq    = RSQ_W'(r_s2.radius) * RSQ_W'(r_s2.radius);
    end

    // stage 4: distance against radius
    always_comb begin
        logic [SUM_W-1:0] dist_sq;
        dist_sq = SUM_W'(r_s3.sq_x) + SUM_W'(r_s3.sq_y);
        n_hit   = r_s3.is_bb ? r_s3.bb_hit : (dist_sq <= SUM_W'(r_s3.rsq));
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) r_s1  <= n_s1;
        if (en2 && r_v1)    r_s2  <= n_s2;
        if (en3 && r_v2)    r_s3  <= n_s3;
        if (en4 && r_v3)    r_hit <= n_hit;
    end

    assign o_valid    = r_v4;
    assign o_touching = r_hit;

endmodule

// File: rtl/core/sot_checker.sv
`timescale 1ns / 1ps
// sot_checker: port-level checks for shape_overlap_test, and the bind that attaches it
// depends on shape_overlap_test and sot_pkg

module sot_checker
    import sot_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    o_stall,
    input logic                    i_a_is_circle,
    input logic signed [POS_W-1:0] i_a_pos_x,
    input logic signed [POS_W-1:0] i_a_pos_y,
    input logic [EXT_W-1:0]        i_a_extent_x,
    input logic [EXT_W-1:0]        i_a_extent_y,
    input logic                    i_b_is_circle,
    input logic signed [POS_W-1:0] i_b_pos_x,
    input logic signed [POS_W-1:0] i_b_pos_y,
    input logic [EXT_W-1:0]        i_b_extent_x,
    input logic [EXT_W-1:0]        i_b_extent_y,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic                    o_touching
);

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // a waiting result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_touching))
        else $error("result changed while stalled");

    // back-pressure only when the pipeline is full behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled result");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered straight after reset");

endmodule

bind shape_overlap_test sot_checker u_sot_checker (.*);

// File: test/tb_shape_overlap_test.sv
`timescale 1ns / 1ps
// tb_shape_overlap_test: self-checking bench for the circle and box contact test
// depends on sot_pkg and shape_overlap_test; expected verdicts come from a local predictor

module tb_shape_overlap_test;
    import sot_pkg::*;

    localparam int ONE        = 256;               // 1.0 in Q.8
    localparam int POS_MIN    = -(1 << (POS_W - 1));
    localparam int POS_MAX    = (1 << (POS_W - 1)) - 1;
    localparam int EXT_MAX    = (1 << EXT_W) - 1;
    localparam int CYCLE_LIMIT = 400000;

    // one shape as carried on the input ports
    typedef struct packed {
        logic                    circle;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [EXT_W-1:0]        ex;
        logic [EXT_W-1:0]        ey;
    } shape_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic                    i_a_is_circle;
    logic signed [POS_W-1:0] i_a_pos_x;
    logic signed [POS_W-1:0] i_a_pos_y;
    logic [EXT_W-1:0]        i_a_extent_x;
    logic [EXT_W-1:0]        i_a_extent_y;
    logic                    i_b_is_circle;
    logic signed [POS_W-1:0] i_b_pos_x;
    logic signed [POS_W-1:0] i_b_pos_y;
    logic [EXT_W-1:0]        i_b_extent_x;
    logic [EXT_W-1:0]        i_b_extent_y;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic                    o_touching;

    bit touching_expected[$];
    bit want_touching;
    int mismatch_count = 0;
    int cycle_count = 0;
    int hold_left = 0;
    bit sender_idle_en = 1'b1;
    bit recv_stall_en = 1'b1;

    shape_overlap_test uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_a_is_circle (i_a_is_circle),
        .i_a_pos_x     (i_a_pos_x),
        .i_a_pos_y     (i_a_pos_y),
        .i_a_extent_x  (i_a_extent_x),
        .i_a_extent_y  (i_a_extent_y),
        .i_b_is_circle (i_b_is_circle),
        .i_b_pos_x     (i_b_pos_x),
        .i_b_pos_y     (i_b_pos_y),
        .i_b_extent_x  (i_b_extent_x),
        .i_b_extent_y  (i_b_extent_y),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_touching    (o_touching)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run limit reached", $time);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: long hold-off when requested, else random stalls if enabled, else none
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (recv_stall_en) begin
            i_stall <= ($urandom_range(99) < 30);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // compare each output transfer with the oldest expected verdict
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (touching_expected.size() == 0) begin
                $display("%0t: unexpected result, expected none, got touching=%0b",
                         $time, o_touching);
                mismatch_count++;
            end else begin
                want_touching = touching_expected.pop_front();
                if (o_touching !== want_touching) begin
                    $display("%0t: touching mismatch, expected %0b, got %0b",
                             $time, want_touching, o_touching);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v;
    endfunction

    // exact contact verdict for a pair of shapes
    function automatic bit predict_touching(shape_t a, shape_t b);
        longint ax, ay, aex, aey, bx, by, bex, bey;
        longint cx, cy, cr, lx, ly, hx, hy, dx, dy, rs;
        logic [1:0] kind;
        bit hit;
        ax  = longint'($signed(a.x));
        ay  = longint'($signed(a.y));
        aex = longint'(a.ex);
        aey = longint'(a.ey);
        bx  = longint'($signed(b.x));
        by  = longint'($signed(b.y));
        bex = longint'(b.ex);
        bey = longint'(b.ey);
        if (a.circle && b.circle) kind = MODE_CIRC_CIRC;
        else if (!a.circle && !b.circle) kind = MODE_BOX_BOX;
        else kind = MODE_CIRC_BOX;
        case (kind)
            MODE_CIRC_CIRC: begin
                dx = ax - bx;
                dy = ay - by;
                rs = aex + bex;
                hit = (dx * dx + dy * dy <= rs * rs);
            end
            MODE_BOX_BOX: begin
                hit = !((ax + aex < bx) || (ax > bx + bex) ||
                        (ay + aey < by) || (ay > by + bey));
            end
            MODE_CIRC_BOX: begin
                // the circle's own radius, whichever side it came in on
                if (a.circle) begin
                    cx = ax; cy = ay; cr = aex;
                    lx = bx; ly = by; hx = bx + bex; hy = by + bey;
                end else begin
                    cx = bx; cy = by; cr = bex;
                    lx = ax; ly = ay; hx = ax + aex; hy = ay + aey;
                end
                dx = clamp_to(cx, lx, hx) - cx;
                dy = clamp_to(cy, ly, hy) - cy;
                hit = (dx * dx + dy * dy <= cr * cr);
            end
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // circle with a random, ignored height
    function automatic shape_t make_circle(int x, int y, int r);
        shape_t s;
        s.circle = 1'b1;
        s.x  = x[POS_W-1:0];
        s.y  = y[POS_W-1:0];
        s.ex = r[EXT_W-1:0];
        s.ey = EXT_W'($urandom);
        return s;
    endfunction

    function automatic shape_t make_box(int x, int y, int w, int h);
        shape_t s;
        s.circle = 1'b0;
        s.x  = x[POS_W-1:0];
        s.y  = y[POS_W-1:0];
        s.ex = w[EXT_W-1:0];
        s.ey = h[EXT_W-1:0];
        return s;
    endfunction

    // after an optional random idle, offer one pair, wait for its transfer, then record the verdict
    task automatic send_pair(input shape_t a, input shape_t b);
        if (sender_idle_en && $urandom_range(99) < 30) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_a_is_circle <= a.circle;
        i_a_pos_x     <= a.x;
        i_a_pos_y     <= a.y;
        i_a_extent_x  <= a.ex;
        i_a_extent_y  <= a.ey;
        i_b_is_circle <= b.circle;
        i_b_pos_x     <= b.x;
        i_b_pos_y     <= b.y;
        i_b_extent_x  <= b.ex;
        i_b_extent_y  <= b.ey;
        do @(posedge i_clk); while (o_stall);
        touching_expected.push_back(predict_touching(a, b));
    endtask

    // sender pauses until every verdict has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (touching_expected.size() != 0);
    endtask

    task automatic test_directed();
        // circle pairs: exact contact, one lsb apart, diagonal, points, range corners
        send_pair(make_circle(0, 0, 3 * ONE), make_circle(5 * ONE, 0, 2 * ONE));
        send_pair(make_circle(0, 0, 3 * ONE), make_circle(5 * ONE + 1, 0, 2 * ONE));
        send_pair(make_circle(0, 0, 2 * ONE), make_circle(3 * ONE, 4 * ONE, 3 * ONE));
        send_pair(make_circle(-ONE, -ONE, 0), make_circle(-ONE, -ONE, 0));
        send_pair(make_circle(POS_MIN, POS_MIN, EXT_MAX),
                  make_circle(POS_MAX, POS_MAX, EXT_MAX));
        send_pair(make_circle(POS_MIN, POS_MAX, EXT_MAX),
                  make_circle(POS_MIN, POS_MAX, EXT_MAX));
        // box pairs: shared edge, one lsb gap, zero-sized, far edges past the range
        send_pair(make_box(0, 0, ONE, ONE), make_box(ONE, 0, ONE, ONE));
        send_pair(make_box(0, 0, ONE, ONE), make_box(0, ONE + 1, ONE, ONE));
        send_pair(make_box(-4 * ONE, -4 * ONE, 8 * ONE, 8 * ONE), make_box(0, 0, 0, 0));
        send_pair(make_box(ONE, ONE, 0, 0), make_box(ONE, ONE, 0, 0));
        send_pair(make_box(POS_MIN, POS_MIN, EXT_MAX, EXT_MAX),
                  make_box(POS_MAX, POS_MAX, EXT_MAX, EXT_MAX));
        send_pair(make_box(POS_MAX - 100, POS_MAX - 100, EXT_MAX, EXT_MAX),
                  make_box(POS_MAX, POS_MAX, 0, 0));
        send_pair(make_box(POS_MAX, 0, EXT_MAX, 0), make_box(POS_MIN, 0, EXT_MAX, 0));
        // circle and box: corner contact, just short, both orders, radius taken from circle
        send_pair(make_circle(4 * ONE, 5 * ONE, 5 * ONE), make_box(0, 0, ONE, ONE));
        send_pair(make_circle(4 * ONE, 5 * ONE, 5 * ONE - 1), make_box(0, 0, ONE, ONE));
        send_pair(make_box(0, 0, ONE, ONE), make_circle(4 * ONE, 5 * ONE, 5 * ONE));
        send_pair(make_box(0, 0, 8 * ONE, 2 * ONE), make_circle(ONE, ONE, 0));
        send_pair(make_box(0, 0, 8 * ONE, 2 * ONE), make_circle(ONE, 3 * ONE, ONE));
        send_pair(make_box(0, 0, 8 * ONE, 2 * ONE), make_circle(ONE, 4 * ONE, ONE));
        send_pair(make_circle(POS_MIN, POS_MIN, EXT_MAX),
                  make_box(POS_MAX, POS_MAX, EXT_MAX, EXT_MAX));
        send_pair(make_box(POS_MIN, POS_MIN, 0, 0),
                  make_circle(POS_MIN + EXT_MAX, POS_MIN, EXT_MAX));
        drain_results();
    endtask

    // mostly shapes near each other at a random scale, some spread over the whole range
    task automatic test_random_pairs(input int count);
        shape_t a, b;
        int k, span, dx, dy;
        for (int n = 0; n < count; n++) begin
            a.circle = 1'($urandom_range(1));
            b.circle = 1'($urandom_range(1));
            a.x = POS_W'($urandom);
            a.y = POS_W'($urandom);
            if ($urandom_range(99) < 15) begin
                b.x  = POS_W'($urandom);
                b.y  = POS_W'($urandom);
                a.ex = EXT_W'($urandom);
                a.ey = EXT_W'($urandom);
                b.ex = EXT_W'($urandom);
                b.ey = EXT_W'($urandom);
            end else begin
                k    = $urandom_range(2, EXT_W);
                span = 1 << (k + 1);
                dx   = int'($urandom_range(0, 2 * span)) - span;
                dy   = int'($urandom_range(0, 2 * span)) - span;
                b.x  = POS_W'(int'(a.x) + dx);
                b.y  = POS_W'(int'(a.y) + dy);
                a.ex = EXT_W'($urandom_range(0, (1 << k) - 1));
                a.ey = EXT_W'($urandom_range(0, (1 << k) - 1));
                b.ex = EXT_W'($urandom_range(0, (1 << k) - 1));
                b.ey = EXT_W'($urandom_range(0, (1 << k) - 1));
            end
            send_pair(a, b);
        end
    endtask

    // back-to-back transfers with neither side idling
    task automatic test_no_idle();
        sender_idle_en = 1'b0;
        recv_stall_en  = 1'b0;
        test_random_pairs(200);
        sender_idle_en = 1'b1;
        recv_stall_en  = 1'b1;
        drain_results();
    endtask

    // long receiver hold-off while the sender keeps offering, so the pipe fills up
    task automatic test_backpressure();
        sender_idle_en = 1'b0;
        hold_left = 60;
        test_random_pairs(40);
        sender_idle_en = 1'b1;
        drain_results();
    endtask

    // stimulus sequence
    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_a_is_circle <= 1'b0;
        i_a_pos_x     <= '0;
        i_a_pos_y     <= '0;
        i_a_extent_x  <= '0;
        i_a_extent_y  <= '0;
        i_b_is_circle <= 1'b0;
        i_b_pos_x     <= '0;
        i_b_pos_y     <= '0;
        i_b_extent_x  <= '0;
        i_b_extent_y  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_pairs(800);
        drain_results();
        test_no_idle();
        test_backpressure();
        test_random_pairs(150);
        drain_results();

        // let any stray result show up
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
